/* rtl/pa2x_pkg.sv */
`timescale 1ns / 1ps

package pa2x_pkg;

    // Scaling modes held in the mode register; the unused code duplicates.
    typedef enum logic [1:0] {
        MODE_DUP   = 2'd0,
        MODE_EPX   = 2'd1,
        MODE_EAGLE = 2'd2,
        MODE_SPARE = 2'd3
    } t_mode;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_PITCH  = 2'd3;

    // Fixed field widths of the stream and configuration ports.
    localparam int WORD_BITS   = 16;
    localparam int OFFSET_BITS = 24;
    localparam int DIM_BITS    = 11;
    localparam int PITCH_BITS  = 13;
    localparam int OUT_BITS    = 4 * WORD_BITS + OFFSET_BITS;

    typedef logic [WORD_BITS-1:0]   t_word;
    typedef logic [OFFSET_BITS-1:0] t_offset;

endpackage

/* rtl/pa2x_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module pa2x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pixel_art_2x_upscaler.sv */
`timescale 1ns / 1ps
// Pipeline: two register stages; an accepted source pixel is registered into stage one, and
// the block formed from it into the output register as stage one advances.
// Throughput: one source pixel per cycle, set by the single-port-pair line stores that
// are read once and written once per pixel; output stalls back up through one stage.
// Reset (synchronous, active low) clears the counters, the window registers, the pipeline
// valids and loads the register defaults; the line stores are not cleared.
module pixel_art_2x_upscaler
    import pa2x_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [PITCH_BITS-1:0] i_cfg_data,
    // Source pixel stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [WORD_BITS-1:0]  s_axis_tdata,  // [15:0] pixel
    input  logic                  s_axis_tuser,  // [0] start_of_frame
    // Output block stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] top_left, [31:16] top_right, [47:32] bottom_left,
    // [63:48] bottom_right, [87:64] block_offset
    output logic [OUT_BITS-1:0]   m_axis_tdata,
    output logic                  m_axis_tlast   // last_of_frame
);

    localparam int PB = (PIXEL_BITS < WORD_BITS) ? PIXEL_BITS : WORD_BITS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = CW + 1;
    localparam int HW = RW + 1;

    typedef logic [PB-1:0] t_pix;

    // Configuration registers.
    t_mode                 r_mode;
    logic [DIM_BITS-1:0]   r_frame_width;
    logic [DIM_BITS-1:0]   r_frame_height;
    logic [PITCH_BITS-1:0] r_pitch;

    // Raster counters.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    // Pipeline stage between the store read and the output register.
    logic          r_s1_valid;
    t_pix          r_s1_pix;
    logic [CW-1:0] r_s1_c;
    logic [RW-1:0] r_s1_r;
    logic          r_s1_last;
    logic          r_s1_byp;
    t_pix          r_s1_fwd_prior;
    t_pix          r_s1_fwd_older;

    // Window columns: a, d, g (column c-2) and b, e, h (column c-1).
    t_pix r_win_a, r_win_d, r_win_g, r_win_b, r_win_e, r_win_h;

    // Output register.
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;
    logic                r_out_last;

    logic [WW-1:0] frame_w;
    logic [HW-1:0] frame_h;
    logic          in_acc;
    logic          s1_adv;
    logic [CW-1:0] col_raw;
    logic [RW-1:0] row_raw;
    logic [CW-1:0] s0_c;
    logic [RW-1:0] s0_r;
    logic          s0_last;
    logic          s0_byp;
    t_pix          s0_pix;

    t_pix prior_q, older_q;
    t_pix f_eff, c_eff;
    t_pix e0, e1, e2, e3;
    logic emit;
    logic [RW-1:0] blk_r;
    logic [CW-1:0] blk_c;
    logic [RW+PITCH_BITS-1:0] row_prod;
    t_offset blk_off;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_EPX;
            r_frame_width  <= DIM_BITS'(320);
            r_frame_height <= DIM_BITS'(240);
            r_pitch        <= PITCH_BITS'(640);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode         <= t_mode'(i_cfg_data[1:0]);
                CFG_WIDTH:  r_frame_width  <= i_cfg_data[DIM_BITS-1:0];
                CFG_HEIGHT: r_frame_height <= i_cfg_data[DIM_BITS-1:0];
                CFG_PITCH:  r_pitch        <= i_cfg_data;
            endcase
        end
    end

    // Clamp the frame size to 1..MAX.
    always_comb begin
        if (r_frame_width == '0) begin
            frame_w = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            frame_w = WW'(MAX_WIDTH);
        end else begin
            frame_w = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            frame_h = HW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            frame_h = HW'(MAX_HEIGHT);
        end else begin
            frame_h = HW'(r_frame_height);
        end
    end

    // Handshakes: stage one moves on when the output register is free or draining.
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Position of the arriving pixel and the counters for the next one.
    always_comb begin
        col_raw = s_axis_tuser ? '0 : r_col;
        row_raw = s_axis_tuser ? '0 : r_row;
        s0_c    = ({1'b0, col_raw} >= frame_w) ? CW'(frame_w - WW'(1)) : col_raw;
        s0_r    = ({1'b0, row_raw} >= frame_h) ? RW'(frame_h - HW'(1)) : row_raw;
        s0_last = ({1'b0, s0_r} == frame_h - HW'(1)) &&
                  ({1'b0, s0_c} == frame_w - WW'(1));
        if (s0_last) begin
            n_col = '0;
            n_row = '0;
        end else if ({1'b0, s0_c} == frame_w - WW'(1)) begin
            n_col = '0;
            n_row = s0_r + RW'(1);
        end else begin
            n_col = s0_c + CW'(1);
            n_row = s0_r;
        end
        s0_pix = s_axis_tdata[PB-1:0];
        // The item leaving stage one writes the same column this cycle.
        s0_byp = r_s1_valid && s1_adv && (r_s1_c == s0_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix       <= s0_pix;
            r_s1_c         <= s0_c;
            r_s1_r         <= s0_r;
            r_s1_last      <= s0_last;
            r_s1_byp       <= s0_byp;
            r_s1_fwd_prior <= r_s1_pix;
            r_s1_fwd_older <= f_eff;
        end
    end

    // Line stores: read at accept, written as the item leaves stage one.
    pa2x_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_prior_row (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_c),
        .i_wdata (r_s1_pix),
        .i_re    (in_acc),
        .i_raddr (s0_c),
        .o_rdata (prior_q)
    );

    pa2x_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_older_row (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_c),
        .i_wdata (f_eff),
        .i_re    (in_acc),
        .i_raddr (s0_c),
        .o_rdata (older_q)
    );

    assign f_eff = r_s1_byp ? r_s1_fwd_prior : prior_q;
    assign c_eff = r_s1_byp ? r_s1_fwd_older : older_q;

    // Slide the window one column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_a <= '0;
            r_win_d <= '0;
            r_win_g <= '0;
            r_win_b <= '0;
            r_win_e <= '0;
            r_win_h <= '0;
        end else if (s1_adv) begin
            r_win_a <= r_win_b;
            r_win_d <= r_win_e;
            r_win_g <= r_win_h;
            r_win_b <= c_eff;
            r_win_e <= f_eff;
            r_win_h <= r_s1_pix;
        end
    end

    // Block rules: EPX and Eagle on the 3x3 neighborhood; other modes duplicate the pixel.
    always_comb begin
        emit  = 1'b1;
        blk_r = r_s1_r;
        blk_c = r_s1_c;
        e0    = r_s1_pix;
        e1    = r_s1_pix;
        e2    = r_s1_pix;
        e3    = r_s1_pix;
        if (r_mode == MODE_EPX || r_mode == MODE_EAGLE) begin
            emit  = (r_s1_r >= RW'(2)) && (r_s1_c >= CW'(2));
            blk_r = r_s1_r - RW'(1);
            blk_c = r_s1_c - CW'(1);
            if (r_mode == MODE_EPX) begin
                if (r_win_b != r_win_h && r_win_d != f_eff) begin
                    e0 = (r_win_d == r_win_b) ? r_win_d : r_win_e;
                    e1 = (r_win_b == f_eff)   ? f_eff   : r_win_e;
                    e2 = (r_win_d == r_win_h) ? r_win_d : r_win_e;
                    e3 = (r_win_h == f_eff)   ? f_eff   : r_win_e;
                end else begin
                    e0 = r_win_e;
                    e1 = r_win_e;
                    e2 = r_win_e;
                    e3 = r_win_e;
                end
            end else begin
                e0 = (r_win_b == r_win_a && r_win_a == r_win_d) ? r_win_d : r_win_e;
                e1 = (r_win_b == c_eff && c_eff == f_eff)       ? f_eff   : r_win_e;
                e2 = (r_win_h == r_win_g && r_win_g == r_win_d) ? r_win_d : r_win_e;
                e3 = (r_win_h == r_s1_pix && r_s1_pix == f_eff) ? f_eff   : r_win_e;
            end
        end
    end

    // Destination offset: 2*row*pitch + 2*col, modulo 2^24.
    assign row_prod = {{PITCH_BITS{1'b0}}, blk_r} * {{RW{1'b0}}, r_pitch};
    assign blk_off  = OFFSET_BITS'({row_prod, 1'b0}) + OFFSET_BITS'({blk_c, 1'b0});

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {blk_off, t_word'(e3), t_word'(e2), t_word'(e1), t_word'(e0)};
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
